// ----- rtl/ita_pkg.sv -----
// ----------------------------------------------------------------------------
// ita_pkg
// Shared types, command codes and character constants of the formatter.
// ----------------------------------------------------------------------------
package ita_pkg;

  localparam logic [2:0] CMD_LIT  = 3'd0;
  localparam logic [2:0] CMD_SDEC = 3'd1;
  localparam logic [2:0] CMD_UDEC = 3'd2;
  localparam logic [2:0] CMD_HEXL = 3'd3;
  localparam logic [2:0] CMD_HEXU = 3'd4;
  localparam logic [2:0] CMD_PTR  = 3'd5;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_UPA   = 8'h41;
  localparam logic [7:0] CH_LOWA  = 8'h61;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_X     = 8'h78;

  localparam logic [4:0] NDIG_DEC = 5'd10;
  localparam logic [4:0] NDIG_H32 = 5'd8;
  localparam logic [4:0] NDIG_H64 = 5'd16;

  typedef struct packed {
    logic       load;
    logic       upper;
    logic [4:0] ndig;
  } ita_ld_t;

  typedef struct packed {
    logic       strobe;
    logic       last;
    logic       active;
  } ita_emit_st_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'b0, d};
    end else begin
      c = (upper ? CH_UPA : CH_LOWA) + {4'b0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

// ----- rtl/ita_dabble.sv -----
// ----------------------------------------------------------------------------
// ita_dabble
// Bit-serial binary to BCD converter, one input bit per cycle.
// ----------------------------------------------------------------------------
module ita_dabble (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] bin_i,
  output logic        busy_o,
  output logic [39:0] bcd_o
);

  logic [31:0] bin_q, bin_d;
  logic [39:0] bcd_q, bcd_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [39:0] adj;

  always_comb begin
    for (int i = 0; i < 10; i++) begin
      adj[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ? bcd_q[i*4 +: 4] + 4'd3 : bcd_q[i*4 +: 4];
    end
  end

  always_comb begin
    bin_d = bin_q;
    bcd_d = bcd_q;
    cnt_d = cnt_q;
    if (start_i) begin
      bin_d = bin_i;
      bcd_d = '0;
      cnt_d = 6'd32;
    end else if (cnt_q != 6'd0) begin
      bcd_d = {adj[38:0], bin_q[31]};
      bin_d = {bin_q[30:0], 1'b0};
      cnt_d = cnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign busy_o = (cnt_q != 6'd0);
  assign bcd_o  = bcd_q;

endmodule

// ----- rtl/ita_emit.sv -----
// ----------------------------------------------------------------------------
// ita_emit
// Digit shift register that drops leading zeros and emits one character
// per cycle once they are dropped, most significant digit first.
// ----------------------------------------------------------------------------
module ita_emit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ita_pkg::ita_ld_t    ld_i,
  input  logic [63:0]         digits_i,
  output ita_pkg::ita_emit_st_t st_o,
  output logic [7:0]          char_o
);

  logic [63:0] digits_q, digits_d;
  logic [4:0]  rem_q, rem_d;
  logic        skip_q, skip_d;
  logic        upper_q, upper_d;
  logic        skipping;
  logic [3:0]  top_dig;

  assign top_dig  = digits_q[63:60];
  assign skipping = skip_q && (top_dig == 4'd0) && (rem_q != 5'd1);

  always_comb begin
    digits_d = digits_q;
    rem_d    = rem_q;
    skip_d   = skip_q;
    upper_d  = upper_q;
    if (ld_i.load) begin
      digits_d = digits_i;
      rem_d    = ld_i.ndig;
      skip_d   = 1'b1;
      upper_d  = ld_i.upper;
    end else if (rem_q != 5'd0) begin
      digits_d = {digits_q[59:0], 4'd0};
      rem_d    = rem_q - 5'd1;
      if (!skipping) begin
        skip_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      skip_q <= 1'b0;
    end else begin
      rem_q  <= rem_d;
      skip_q <= skip_d;
    end
  end

  always_ff @(posedge clk_i) begin
    digits_q <= digits_d;
    upper_q  <= upper_d;
  end

  assign st_o.active = (rem_q != 5'd0);
  assign st_o.strobe = (rem_q != 5'd0) && !skipping;
  assign st_o.last   = (rem_q == 5'd1);
  assign char_o      = ita_pkg::digit_char(top_dig, upper_q);

endmodule

// ----- rtl/integer_to_ascii_formatter.sv -----
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// Turns one conversion request into a run of ASCII characters.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Characters
// appear one per cycle, except while leading zeros are dropped, on
// out_char_o with valid_o high for one cycle each, and last_o marks the final
// one; the receiver cannot stall them, so it must take every character in
// the cycle it is shown. Each character leaves through an output register
// in the cycle after it is formed, and a new request can be taken in the
// cycle that shows the final character. A literal keeps busy high for 1
// cycle. Decimal modes run the bit-serial BCD conversion, one input bit at a
// time, pass the digits on, then step through the digit positions (ten in
// all) to drop leading zeros and emit digits, after a minus sign if negative.
// Hex modes do the same over 8 or 16 nibble positions, after the 0x prefix
// for a pointer. Commands 6 and 7 are dropped without any output.
module integer_to_ascii_formatter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  cmd_i,
  input  logic [63:0] value_i,
  output logic        valid_o,
  output logic [7:0]  out_char_o,
  output logic        last_o
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_LIT    = 7'b0000010,
    S_CONV   = 7'b0000100,
    S_MINUS  = 7'b0001000,
    S_PFX0   = 7'b0010000,
    S_PFX1   = 7'b0100000,
    S_DIGITS = 7'b1000000
  } state_e;

  state_e      state_q, state_d;
  logic [63:0] value_q, value_d;
  logic        neg_q, neg_d;
  logic        valid_q, valid_d;
  logic [7:0]  char_q, char_d;
  logic        last_q, last_d;

  logic        dab_start;
  logic [31:0] mag;
  logic        dab_busy;
  logic [39:0] bcd;

  ita_pkg::ita_ld_t      ld;
  logic [63:0]           ld_digits;
  ita_pkg::ita_emit_st_t est;
  logic [7:0]            emit_char;

  assign mag = (cmd_i == ita_pkg::CMD_SDEC && value_i[31]) ?
               (~value_i[31:0] + 32'd1) : value_i[31:0];

  ita_dabble u_dabble (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(dab_start),
    .bin_i  (mag),
    .busy_o (dab_busy),
    .bcd_o  (bcd)
  );

  ita_emit u_emit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ld_i    (ld),
    .digits_i(ld_digits),
    .st_o    (est),
    .char_o  (emit_char)
  );

  always_comb begin
    state_d   = state_q;
    value_d   = value_q;
    neg_d     = neg_q;
    valid_d   = 1'b0;
    char_d    = char_q;
    last_d    = 1'b0;
    dab_start = 1'b0;
    ld        = '0;
    ld_digits = {bcd, 24'd0};
    case (state_q)
      S_IDLE: begin
        if (start) begin
          value_d = value_i;
          neg_d   = (cmd_i == ita_pkg::CMD_SDEC) && value_i[31];
          case (cmd_i)
            ita_pkg::CMD_LIT: begin
              state_d = S_LIT;
            end
            ita_pkg::CMD_SDEC, ita_pkg::CMD_UDEC: begin
              dab_start = 1'b1;
              state_d   = S_CONV;
            end
            ita_pkg::CMD_HEXL, ita_pkg::CMD_HEXU: begin
              ld.load   = 1'b1;
              ld.upper  = (cmd_i == ita_pkg::CMD_HEXU);
              ld.ndig   = ita_pkg::NDIG_H32;
              ld_digits = {value_i[31:0], 32'd0};
              state_d   = S_DIGITS;
            end
            ita_pkg::CMD_PTR: begin
              state_d = S_PFX0;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_LIT: begin
        valid_d = 1'b1;
        char_d  = value_q[7:0];
        last_d  = 1'b1;
        state_d = S_IDLE;
      end
      S_CONV: begin
        if (!dab_busy) begin
          if (neg_q) begin
            state_d = S_MINUS;
          end else begin
            ld.load = 1'b1;
            ld.ndig = ita_pkg::NDIG_DEC;
            state_d = S_DIGITS;
          end
        end
      end
      S_MINUS: begin
        valid_d = 1'b1;
        char_d  = ita_pkg::CH_MINUS;
        ld.load = 1'b1;
        ld.ndig = ita_pkg::NDIG_DEC;
        state_d = S_DIGITS;
      end
      S_PFX0: begin
        valid_d = 1'b1;
        char_d  = ita_pkg::CH_ZERO;
        state_d = S_PFX1;
      end
      S_PFX1: begin
        valid_d   = 1'b1;
        char_d    = ita_pkg::CH_X;
        ld.load   = 1'b1;
        ld.ndig   = ita_pkg::NDIG_H64;
        ld_digits = value_q;
        state_d   = S_DIGITS;
      end
      S_DIGITS: begin
        if (est.strobe) begin
          valid_d = 1'b1;
          char_d  = emit_char;
          last_d  = est.last;
        end
        if (est.last || !est.active) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    neg_q   <= neg_d;
    char_q  <= char_d;
  end

  assign busy       = (state_q != S_IDLE);
  assign valid_o    = valid_q;
  assign out_char_o = char_q;
  assign last_o     = last_q;

endmodule
